### hdl/mcg_pkg.sv
// Shared types and constants of the metronome click generator.
package mcg_pkg;

   // Q30 value of pi/2, the argument range of the quarter-wave table
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   // 3*sqrt(3)/8 in Q0.16
   localparam logic [15:0] SCALE_Q16 = 16'd42567;
   localparam logic [15:0] ENV_START = 16'hFFFF;
   localparam int unsigned SINE_MAX = 32767;

   localparam logic [15:0] CLICK_LENGTH_RESET = 16'd4800;
   localparam logic [15:0] ENVELOPE_STEP_RESET = 16'd14;
   localparam logic [31:0] MAJOR_STEP_RESET = 32'd107374182;
   localparam logic [31:0] OVERTONE_STEP_RESET = 32'd322122547;
   localparam logic [31:0] MINOR_STEP_RESET = 32'd71582788;

   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_CLICK_LENGTH   = 3'd0,
      CSR_ENVELOPE_STEP  = 3'd1,
      CSR_MAJOR_STEP     = 3'd2,
      CSR_OVERTONE_STEP  = 3'd3,
      CSR_MINOR_STEP     = 3'd4,
      CSR_MAJOR_ENABLED  = 3'd5,
      CSR_MINOR_ENABLED  = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADDR_MAIN,
      S_ADDR_HARM,
      S_MIX_MAIN,
      S_MIX_HARM,
      S_MUL_ENV,
      S_MUL_SCALE,
      S_ROUND,
      S_DONE
   } state_type;

endpackage

### hdl/metronome_click_generator_core.sv
// Metronome click generator: sequencer, sine table, shared multiplier and output register.
//
// One request word arrives per audio sample: req_beat_here starts a click of the kind
// given by req_beat_is_major at sample index zero. One response word leaves per request:
// rsp_audio_sample (signed Q1.(SAMPLE_WIDTH-1), zero when silent), rsp_click_active and
// rsp_click_major. Registers are written through the csr_ channel, which is always ready;
// writes are meant for idle periods between samples.
// A sample that sounds passes, from acceptance until the block is ready again, through
// two table reads through the single sine table port, two passes of the shared
// 34x16 multiplier (magnitude times envelope, then times the 3*sqrt(3)/8 scale), a
// rounding step and the hand-off into the response register. A silent sample goes
// straight to the hand-off. The response appears in rsp_ valid in the cycle after it.
// The response register decouples the channels: a new request is taken while a
// finished response still waits; if the receiver stalls, the next finished word
// holds in the sequencer until the response register frees up.
// Synchronous reset restores the register defaults, silences any click and drops
// any pending response. The sine table is a constant ROM and needs no fill.
module metronome_click_generator_core
   import mcg_pkg::*;
#(
   parameter int SINE_TABLE_DEPTH = 1024,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_beat_here,
   input  logic                           req_beat_is_major,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_audio_sample,
   output logic                           rsp_click_active,
   output logic                           rsp_click_major,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [31:0]                    csr_wdata
);

   localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int SHIFT = 50 - SAMPLE_WIDTH;
   localparam logic [SAMPLE_WIDTH:0] LIMIT = (SAMPLE_WIDTH + 1)'((1 << (SAMPLE_WIDTH - 1)) - 1);

   typedef logic [14:0] rom_type [0:SINE_TABLE_DEPTH];

   function automatic rom_type build_rom();
      rom_type            rom;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        v;
      logic signed [63:0] sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x = (64'(k) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
         x2 = (x * x) >> 30;
         term = x;
         sum = $signed(x);
         for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         v = (64'(sum) * 64'(SINE_MAX) + (64'd1 << 29)) >> 30;
         if (v > 64'(SINE_MAX)) begin
            v = 64'(SINE_MAX);
         end
         rom[k] = v[14:0];
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // configuration
   logic [15:0] click_length_ff;
   logic [15:0] envelope_step_ff;
   logic [31:0] major_step_ff;
   logic [31:0] overtone_step_ff;
   logic [31:0] minor_step_ff;
   logic        major_enabled_ff;
   logic        minor_enabled_ff;

   // click state
   logic        sounding_ff;
   logic        sounding_major_ff;
   logic [15:0] sample_index_ff;
   logic [15:0] envelope_level_ff;
   logic [31:0] main_phase_ff;
   logic [31:0] harmonic_phase_ff;

   // datapath
   state_type              state_ff;
   state_type              state_in;
   logic [DEPTH_W-1:0]     rom_addr_ff;
   logic [14:0]            rom_q_ff;
   logic                   neg_main_ff;
   logic                   neg_harm_ff;
   logic signed [18:0]     acc_ff;
   logic [17:0]            mag_ff;
   logic                   neg_ff;
   logic                   act_ff;
   logic [49:0]            prod_ff;
   logic [SAMPLE_WIDTH-2:0] round_ff;

   logic                          rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                          rsp_active_ff;
   logic                          rsp_major_ff;

   // combinational
   logic                      accept;
   logic                      load_rsp;
   logic                      eff_major;
   logic [15:0]               eff_index;
   logic                      eff_enabled;
   logic                      act;
   logic [31:0]               lookup_phase;
   logic [30+DEPTH_W-1:0]     scaled_off;
   logic [DEPTH_W-1:0]        raw_index;
   logic [DEPTH_W-1:0]        table_index;
   logic signed [18:0]        main_val;
   logic signed [18:0]        harm_val;
   logic signed [18:0]        mix_sum;
   logic [33:0]               mul_a;
   logic [15:0]               mul_b;
   logic [49:0]               mul_p;
   logic [50:0]               rounded_sum;
   logic [SAMPLE_WIDTH:0]     rounded;
   logic [15:0]               index_next;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;

   assign csr_ready = 1'b1;
   assign accept = req_valid && req_ready;
   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // state as seen by this sample after a possible beat restart
   assign eff_major = req_beat_here ? req_beat_is_major : sounding_major_ff;
   assign eff_index = req_beat_here ? 16'd0 : sample_index_ff;
   assign eff_enabled = eff_major ? major_enabled_ff : minor_enabled_ff;
   assign act = (req_beat_here || sounding_ff) && eff_enabled && (eff_index < click_length_ff);

   // table address: quadrant from the top phase bits, mirror in odd quadrants
   assign lookup_phase = (state_ff == S_ADDR_MAIN) ? main_phase_ff : harmonic_phase_ff;
   assign scaled_off = {{DEPTH_W{1'b0}}, lookup_phase[29:0]}
                     * (30 + DEPTH_W)'(SINE_TABLE_DEPTH);
   assign raw_index = scaled_off[30 +: DEPTH_W];
   assign table_index = lookup_phase[30] ? DEPTH_W'(SINE_TABLE_DEPTH) - raw_index : raw_index;

   assign main_val = 19'(rom_q_ff) <<< 2;
   assign harm_val = 19'(rom_q_ff);
   assign mix_sum = acc_ff + (sounding_major_ff ? (neg_harm_ff ? -harm_val : harm_val)
                                                : 19'sd0);

   // shared multiplier: magnitude times envelope, then times the scale
   always_comb begin
      if (state_ff == S_MUL_SCALE) begin
         mul_a = prod_ff[33:0];
         mul_b = SCALE_Q16;
      end else begin
         mul_a = 34'(mag_ff);
         mul_b = envelope_level_ff;
      end
   end
   assign mul_p = mul_a * 50'(mul_b);

   assign rounded_sum = {1'b0, prod_ff} + (51'd1 << (SHIFT - 1));
   assign rounded = rounded_sum[50:SHIFT];
   assign index_next = sample_index_ff + 16'd1;
   assign sample_out = neg_ff ? -$signed({1'b0, round_ff}) : $signed({1'b0, round_ff});

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = act ? S_ADDR_MAIN : S_DONE;
            end
         end
         S_ADDR_MAIN: state_in = S_ADDR_HARM;
         S_ADDR_HARM: state_in = S_MIX_MAIN;
         S_MIX_MAIN:  state_in = S_MIX_HARM;
         S_MIX_HARM:  state_in = S_MUL_ENV;
         S_MUL_ENV:   state_in = S_MUL_SCALE;
         S_MUL_SCALE: state_in = S_ROUND;
         S_ROUND:     state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         click_length_ff <= CLICK_LENGTH_RESET;
         envelope_step_ff <= ENVELOPE_STEP_RESET;
         major_step_ff <= MAJOR_STEP_RESET;
         overtone_step_ff <= OVERTONE_STEP_RESET;
         minor_step_ff <= MINOR_STEP_RESET;
         major_enabled_ff <= 1'b1;
         minor_enabled_ff <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CLICK_LENGTH:  click_length_ff <= csr_wdata[15:0];
            CSR_ENVELOPE_STEP: envelope_step_ff <= csr_wdata[15:0];
            CSR_MAJOR_STEP:    major_step_ff <= csr_wdata;
            CSR_OVERTONE_STEP: overtone_step_ff <= csr_wdata;
            CSR_MINOR_STEP:    minor_step_ff <= csr_wdata;
            CSR_MAJOR_ENABLED: major_enabled_ff <= csr_wdata[0];
            CSR_MINOR_ENABLED: minor_enabled_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // click state: restart on a beat, advance once per sounding sample
   always_ff @(posedge clock) begin
      if (reset) begin
         sounding_ff <= 1'b0;
         sounding_major_ff <= 1'b0;
         sample_index_ff <= 16'd0;
         envelope_level_ff <= 16'd0;
         main_phase_ff <= 32'd0;
         harmonic_phase_ff <= 32'd0;
      end else if (accept) begin
         sounding_ff <= act;
         if (req_beat_here) begin
            sounding_major_ff <= req_beat_is_major;
            sample_index_ff <= 16'd0;
            envelope_level_ff <= ENV_START;
            main_phase_ff <= 32'd0;
            harmonic_phase_ff <= 32'd0;
         end
      end else if (state_ff == S_MUL_ENV) begin
         sample_index_ff <= index_next;
         if (sounding_major_ff) begin
            main_phase_ff <= main_phase_ff + major_step_ff;
            harmonic_phase_ff <= harmonic_phase_ff + overtone_step_ff;
         end else begin
            main_phase_ff <= main_phase_ff + minor_step_ff;
         end
         envelope_level_ff <= (envelope_level_ff > envelope_step_ff)
                            ? envelope_level_ff - envelope_step_ff : 16'd0;
         if (index_next >= click_length_ff) begin
            sounding_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rom_q_ff <= SINE_ROM[rom_addr_ff];
      case (state_ff)
         S_IDLE: begin
            act_ff <= act;
            round_ff <= '0;
            neg_ff <= 1'b0;
         end
         S_ADDR_MAIN: begin
            rom_addr_ff <= table_index;
            neg_main_ff <= lookup_phase[31];
         end
         S_ADDR_HARM: begin
            rom_addr_ff <= table_index;
            neg_harm_ff <= lookup_phase[31];
         end
         S_MIX_MAIN: begin
            acc_ff <= neg_main_ff ? -main_val : main_val;
         end
         S_MIX_HARM: begin
            neg_ff <= mix_sum[18];
            mag_ff <= mix_sum[18] ? 18'(-mix_sum) : 18'(mix_sum);
         end
         S_MUL_ENV, S_MUL_SCALE: begin
            prod_ff <= mul_p;
         end
         S_ROUND: begin
            round_ff <= (rounded > LIMIT) ? LIMIT[SAMPLE_WIDTH-2:0]
                                          : rounded[SAMPLE_WIDTH-2:0];
         end
         default: ;
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_sample_ff <= act_ff ? sample_out : '0;
         rsp_active_ff <= act_ff;
         rsp_major_ff <= act_ff && sounding_major_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_audio_sample = rsp_sample_ff;
   assign rsp_click_active = rsp_active_ff;
   assign rsp_click_major = rsp_major_ff;

   a_major_needs_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_click_major |-> rsp_click_active)
      else $error("major flag on a silent word");

   a_silent_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_click_active |-> rsp_audio_sample == '0)
      else $error("silent word carries a nonzero sample");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a sample is in flight");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside hand-off");

endmodule

### tb/metronome_click_generator_core_tb.sv
// Self-checking testbench for the metronome click generator core.
module metronome_click_generator_core_tb
   import mcg_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SINE_DEPTH = 1024;
   localparam int SAMPLE_W = 16;
   localparam int ROUND_SHIFT = 50 - SAMPLE_W;
   localparam longint unsigned SAMPLE_LIMIT = (64'd1 << (SAMPLE_W - 1)) - 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam int RANDOM_PHASES = 10;
   localparam int WORDS_PER_PHASE = 40;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 30;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] audio_sample;
      logic                       click_active;
      logic                       click_major;
   } click_word_type;

   class click_sample_tracker;
      logic [15:0] click_length;
      logic [15:0] envelope_step;
      logic [31:0] major_step;
      logic [31:0] overtone_step;
      logic [31:0] minor_step;
      logic        major_on;
      logic        minor_on;

      logic        sounding;
      logic        sounding_major;
      logic [15:0] sample_index;
      logic [15:0] envelope_level;
      logic [31:0] main_phase;
      logic [31:0] harmonic_phase;

      int unsigned quarter_wave[0:SINE_DEPTH];
      click_word_type pending_words[$];
      int unsigned errors;

      function new();
         for (int k = 0; k <= SINE_DEPTH; k++) quarter_wave[k] = table_entry(k);
         click_length = CLICK_LENGTH_RESET;
         envelope_step = ENVELOPE_STEP_RESET;
         major_step = MAJOR_STEP_RESET;
         overtone_step = OVERTONE_STEP_RESET;
         minor_step = MINOR_STEP_RESET;
         major_on = 1'b1;
         minor_on = 1'b1;
         sounding = 1'b0;
         sounding_major = 1'b0;
         sample_index = '0;
         envelope_level = '0;
         main_phase = '0;
         harmonic_phase = '0;
         errors = 0;
      endfunction

      // Taylor series of sin in Q30, rounded to 15 bits
      function int unsigned table_entry(int unsigned k);
         longint unsigned x, x2, term, v;
         longint sum;
         x = (64'(k) * 64'(HALF_PI_Q30)) / 64'(SINE_DEPTH);
         x2 = (x * x) >> 30;
         term = x;
         sum = longint'(x);
         for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
         end
         if (sum < 0) sum = 0;
         v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (v > 64'(SINE_MAX)) v = 64'(SINE_MAX);
         return int'(v);
      endfunction

      function int table_sine(logic [31:0] ph);
         int unsigned idx;
         int v;
         idx = int'((64'(ph[29:0]) * 64'(SINE_DEPTH)) >> 30);
         if (ph[30]) idx = SINE_DEPTH - idx;
         if (idx > SINE_DEPTH) idx = SINE_DEPTH;
         v = int'(quarter_wave[idx]);
         return ph[31] ? -v : v;
      endfunction

      function void write_register(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] data);
         case (idx)
            CSR_CLICK_LENGTH:  click_length = data[15:0];
            CSR_ENVELOPE_STEP: envelope_step = data[15:0];
            CSR_MAJOR_STEP:    major_step = data;
            CSR_OVERTONE_STEP: overtone_step = data;
            CSR_MINOR_STEP:    minor_step = data;
            CSR_MAJOR_ENABLED: major_on = data[0];
            CSR_MINOR_ENABLED: minor_on = data[0];
            default: ;
         endcase
      endfunction

      function click_word_type next_sample(logic beat, logic major);
         click_word_type w;
         int mix;
         logic neg;
         longint unsigned mag, prod;
         w = '0;
         if (beat) begin
            sounding_major = major;
            sample_index = '0;
            envelope_level = ENV_START;
            main_phase = '0;
            harmonic_phase = '0;
            sounding = 1'b1;
         end
         // drop a click whose kind is off or whose length has run out
         if (sounding && (!(sounding_major ? major_on : minor_on) ||
                          sample_index >= click_length))
            sounding = 1'b0;
         if (sounding) begin
            mix = 4 * table_sine(main_phase);
            if (sounding_major) mix += table_sine(harmonic_phase);
            neg = (mix < 0);
            mag = 64'(neg ? -mix : mix);
            prod = mag * 64'(envelope_level) * 64'(SCALE_Q16);
            prod = (prod + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
            if (prod > SAMPLE_LIMIT) prod = SAMPLE_LIMIT;
            w.audio_sample = neg ? SAMPLE_W'(-prod) : SAMPLE_W'(prod);
            w.click_active = 1'b1;
            w.click_major = sounding_major;
            sample_index++;
            if (sounding_major) begin
               main_phase += major_step;
               harmonic_phase += overtone_step;
            end else begin
               main_phase += minor_step;
            end
            envelope_level = (envelope_level > envelope_step) ?
                             envelope_level - envelope_step : 16'd0;
            if (sample_index >= click_length) sounding = 1'b0;
         end
         return w;
      endfunction

      function void note_request(logic beat, logic major);
         pending_words.push_back(next_sample(beat, major));
      endfunction

      function void check_response(click_word_type got);
         click_word_type want;
         if (pending_words.size() == 0) begin
            $error("response word with none pending: audio_sample %0d", got.audio_sample);
            errors++;
            return;
         end
         want = pending_words.pop_front();
         if (got.audio_sample !== want.audio_sample) begin
            $error("audio_sample: expected %0d, actual %0d", want.audio_sample,
                   got.audio_sample);
            errors++;
         end
         if (got.click_active !== want.click_active) begin
            $error("click_active: expected %0b, actual %0b", want.click_active,
                   got.click_active);
            errors++;
         end
         if (got.click_major !== want.click_major) begin
            $error("click_major: expected %0b, actual %0b", want.click_major,
                   got.click_major);
            errors++;
         end
      endfunction

      function void check_leftovers();
         if (pending_words.size() != 0) begin
            $error("%0d response words never arrived", pending_words.size());
            errors += pending_words.size();
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_beat_here = 1'b0;
   logic                       req_beat_is_major = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_audio_sample;
   logic                       rsp_click_active;
   logic                       rsp_click_major;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0]                csr_wdata = '0;

   int send_gap_pct = 16;
   int rsp_stall_pct = 79;

   click_sample_tracker clicks = new();

   metronome_click_generator_core #(
      .SINE_TABLE_DEPTH(SINE_DEPTH),
      .SAMPLE_WIDTH(SAMPLE_W)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_beat_here(req_beat_here),
      .req_beat_is_major(req_beat_is_major),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_audio_sample(rsp_audio_sample),
      .rsp_click_active(rsp_click_active),
      .rsp_click_major(rsp_click_major),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         clicks.note_request(req_beat_here, req_beat_is_major);
      if (!reset && rsp_valid && rsp_ready)
         clicks.check_response('{rsp_audio_sample, rsp_click_active, rsp_click_major});
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // leave valid high on return so back-to-back words need no second assignment
   task automatic send_word(input logic beat, input logic major);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_beat_here <= beat;
      req_beat_is_major <= major;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (clicks.pending_words.size() != 0);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      clicks.write_register(idx, data);
   endtask

   task automatic set_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                               input logic [31:0] data);
      write_csr(idx, data);
      csr_valid <= 1'b0;
   endtask

   // fill the unused upper bits with noise; the block keeps only the low bits
   task automatic apply_settings(input logic [15:0] len, input logic [15:0] env,
                                 input logic [31:0] maj, input logic [31:0] ovt,
                                 input logic [31:0] mnr, input logic maj_en,
                                 input logic min_en);
      write_csr(CSR_UNUSED_INDEX, $urandom());
      write_csr(CSR_CLICK_LENGTH, ($urandom() & 32'hFFFF_0000) | 32'(len));
      write_csr(CSR_ENVELOPE_STEP, ($urandom() & 32'hFFFF_0000) | 32'(env));
      write_csr(CSR_MAJOR_STEP, maj);
      write_csr(CSR_OVERTONE_STEP, ovt);
      write_csr(CSR_MINOR_STEP, mnr);
      write_csr(CSR_MAJOR_ENABLED, ($urandom() & ~32'd1) | 32'(maj_en));
      write_csr(CSR_MINOR_ENABLED, ($urandom() & ~32'd1) | 32'(min_en));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_length();
      case ($urandom_range(0, 19))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'd1;
         3: return 16'($urandom());
         default: return 16'($urandom_range(2, 40));
      endcase
   endfunction

   function automatic logic [15:0] pick_envelope();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 64));
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [31:0] pick_step();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: restart a click of either kind while one sounds
      send_word(1'b0, 1'b1);
      send_word(1'b1, 1'b1);
      repeat (3) send_word(1'b0, 1'b0);
      send_word(1'b1, 1'b0);
      repeat (2) send_word(1'b0, 1'b1);
      send_word(1'b1, 1'b1);
      send_word(1'b0, 1'b0);
      wait_for_results();

      // short clicks, full envelope drop, largest phase steps
      apply_settings(16'd3, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     1'b1, 1'b1);
      send_word(1'b1, 1'b1);
      repeat (3) send_word(1'b0, 1'b0);
      send_word(1'b1, 1'b0);
      repeat (3) send_word(1'b0, 1'b0);
      wait_for_results();

      // beat of a disabled kind gives silence; a beat of the enabled kind still sounds
      apply_settings(16'd1, 16'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1);
      send_word(1'b1, 1'b1);
      send_word(1'b1, 1'b0);
      send_word(1'b0, 1'b0);
      wait_for_results();

      // zero length: a beat stays silent
      set_register(CSR_CLICK_LENGTH, 32'd0);
      send_word(1'b1, 1'b0);
      wait_for_results();

      // disable the sounding kind in the middle of a click
      apply_settings(16'hFFFF, 16'd100, MAJOR_STEP_RESET, OVERTONE_STEP_RESET,
                     MINOR_STEP_RESET, 1'b1, 1'b1);
      send_word(1'b1, 1'b0);
      send_word(1'b0, 1'b0);
      wait_for_results();
      set_register(CSR_MINOR_ENABLED, 32'd0);
      send_word(1'b0, 1'b0);
      wait_for_results();

      // shorten the click below the running index
      set_register(CSR_MINOR_ENABLED, 32'd1);
      send_word(1'b1, 1'b1);
      repeat (2) send_word(1'b0, 1'b1);
      wait_for_results();
      set_register(CSR_CLICK_LENGTH, 32'd1);
      send_word(1'b0, 1'b0);
      wait_for_results();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         if (ph == 4) begin
            send_gap_pct = 79;
            rsp_stall_pct = 16;
         end else if (ph == 7) begin
            send_gap_pct = 0;
            rsp_stall_pct = 0;
         end
         apply_settings(pick_length(), pick_envelope(), pick_step(), pick_step(),
                        pick_step(), $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            send_word($urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)));
            // hold off now and then until every pending word is back
            if (i < WORDS_PER_PHASE - 1 && $urandom_range(0, 39) == 0) wait_for_results();
         end
         wait_for_results();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      clicks.check_leftovers();
      if (clicks.errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
